// ===== src/nearest_neighbor_plane_scaler_top_macros.svh =====
// Assertion macros shared by the plane scaler RTL.
`ifndef NEAREST_NEIGHBOR_PLANE_SCALER_TOP_MACROS_SVH
`define NEAREST_NEIGHBOR_PLANE_SCALER_TOP_MACROS_SVH

`ifndef ASSERT_OFF

// Check a property on every clock edge outside reset.
`define NNPS_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that a condition in one cycle is followed by another in the next.
`define NNPS_ASSERT_NEXT(lbl, clk, rst, cond, conseq, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) else $error(msg);

`else

`define NNPS_ASSERT(lbl, clk, rst, prop, msg)
`define NNPS_ASSERT_NEXT(lbl, clk, rst, cond, conseq, msg)

`endif

`endif

// ===== src/nnps_pkg.sv =====
// Shared constants and codes for the nearest-neighbor plane scaler.
package nnps_pkg;

  localparam int STORE_ADDR_BITS_DEF = 16;
  localparam int MAX_DIM_DEF         = 1024;

  localparam int LOAD_ADDR_W = 16;
  localparam int PIXEL_W     = 8;
  localparam int CFG_W       = 11;
  localparam int APB_DATA_W  = 32;
  localparam int PADDR_W     = 5;
  localparam int REG_IDX_W   = 3;

  // Register indexes (byte address is 4 times the index)
  localparam logic [REG_IDX_W-1:0] REG_SRC_WIDTH  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_SRC_HEIGHT = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_DST_WIDTH  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_DST_HEIGHT = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_ROW_STRIDE = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_ROTATE_CCW = 3'd5;

  // Request types
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_EMIT = 1'b1;

endpackage

// ===== src/nnps_req_if.sv =====
// Request channel: source byte loads and pixel requests.
interface nnps_req_if;
  logic                             valid;
  logic                             ready;
  logic                             req_type;
  logic [nnps_pkg::LOAD_ADDR_W-1:0] load_addr;
  logic [nnps_pkg::PIXEL_W-1:0]     load_pixel;

  modport source (output valid, output req_type, output load_addr, output load_pixel,
                  input ready);
  modport sink (input valid, input req_type, input load_addr, input load_pixel,
                output ready);
endinterface

// ===== src/nnps_rsp_if.sv =====
// Response channel: destination pixels with line and frame marks.
interface nnps_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [nnps_pkg::PIXEL_W-1:0] pixel;
  logic                         line_end;
  logic                         frame_last;

  modport source (output valid, output pixel, output line_end, output frame_last,
                  input ready);
  modport sink (input valid, input pixel, input line_end, input frame_last,
                output ready);
endinterface

// ===== src/nnps_div.sv =====
// Restoring divider, one quotient bit per cycle.
module nnps_div #(
  parameter int W = 11
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] num,
  input  logic [W-1:0] den,
  output logic         done,
  output logic [W-1:0] quot,
  output logic [W-1:0] rem
);

  localparam int CNT_W = $clog2(W + 1);

  logic [W-1:0]     q;
  logic [W-1:0]     r;
  logic [W-1:0]     d;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done_r;
  logic [W:0]       r_sh;
  logic             fits;

  assign r_sh = {r, q[W-1]};
  assign fits = r_sh >= {1'b0, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      done_r <= 1'b0;
      cnt    <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy   <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q <= num;
      r <= '0;
      d <= den;
    end else if (busy) begin
      if (fits) begin
        r <= W'(r_sh - {1'b0, d});
        q <= {q[W-2:0], 1'b1};
      end else begin
        r <= r_sh[W-1:0];
        q <= {q[W-2:0], 1'b0};
      end
    end
  end

  assign done = done_r;
  assign quot = q;
  assign rem  = r;

endmodule

// ===== src/nearest_neighbor_plane_scaler_top.sv =====
// Nearest-neighbor plane scaler: source byte store, scan walker and output register.
//
// Usage: write the size registers over APB while the block is idle, then send
// req transactions. A load transaction (req_type 0) writes one byte into the
// source store and gives no response. An emit transaction (req_type 1) gives
// one rsp transaction carrying the next destination pixel, with line_end on the
// last pixel of a line and frame_last on the last pixel of the plane; after
// frame_last the next emit starts a new scan. Any register write aborts a scan.
// An emit inside a running scan is read from the store into the read stage and
// then moved into the output register that drives rsp; the block takes one
// transaction per cycle while rsp keeps up. The first emit of a scan runs both
// axis divisions on the bit-serial dividers, one bit per cycle; its pixel is
// read once both are done, and req is not taken until that read is issued.
// The store is one single-port-per-side synchronous memory: one write for loads
// and one registered read per pixel.
// Reset clears the registers to their defaults and ends any scan; the store is
// not cleared. When rsp stalls, one pixel waits in the output register and one
// in the read stage; req is held off once both are full.
`include "nearest_neighbor_plane_scaler_top_macros.svh"

module nearest_neighbor_plane_scaler_top #(
  parameter int STORE_ADDR_BITS = nnps_pkg::STORE_ADDR_BITS_DEF,
  parameter int MAX_DIM         = nnps_pkg::MAX_DIM_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  nnps_req_if.sink                          req,
  nnps_rsp_if.source                        rsp,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [nnps_pkg::PADDR_W-1:0]      paddr,
  input  logic [nnps_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [nnps_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready
);

  localparam int AW    = STORE_ADDR_BITS;
  localparam int DEPTH = 1 << STORE_ADDR_BITS;
  localparam int CW    = $clog2(MAX_DIM + 1);
  localparam int RW    = CW + 1;
  localparam int EW    = CW + 2;

  typedef enum logic [2:0] {
    S_RUN   = 3'b001,
    S_DIV   = 3'b010,
    S_ISSUE = 3'b100
  } state_t;

  // Configuration registers
  logic [nnps_pkg::CFG_W-1:0] src_width;
  logic [nnps_pkg::CFG_W-1:0] src_height;
  logic [nnps_pkg::CFG_W-1:0] dst_width;
  logic [nnps_pkg::CFG_W-1:0] dst_height;
  logic [nnps_pkg::CFG_W-1:0] row_stride;
  logic                       rotate_ccw;

  logic                          cfg_wr;
  logic [nnps_pkg::REG_IDX_W-1:0] cfg_idx;
  logic                          cfg_hit;

  // Clamped sizes
  logic [CW-1:0] sw_c, sh_c, dw_c, dh_c, st_c;

  // Scan state
  state_t        state;
  logic          scan_active;
  logic          rot_s;
  logic [CW-1:0] stride_s;
  logic [CW-1:0] sw_s;
  logic [CW-1:0] inner_len;
  logic [CW-1:0] outer_len;
  logic [CW-1:0] inner_count;
  logic [CW-1:0] outer_count;
  logic [EW-1:0] inner_error;
  logic [EW-1:0] outer_error;
  logic [RW-1:0] inner_rem;
  logic [RW-1:0] outer_rem;
  logic [AW-1:0] inner_step;
  logic [AW-1:0] inner_extra;
  logic [AW-1:0] outer_step;
  logic [AW-1:0] outer_extra;
  logic [AW-1:0] line_base;
  logic [AW-1:0] read_addr;

  // Divider hookup
  logic          div_start;
  logic [CW-1:0] div_i_num, div_i_den, div_o_num, div_o_den;
  logic          div_i_done, div_o_done;
  logic [CW-1:0] div_i_quot, div_i_rem, div_o_quot, div_o_rem;
  logic [2*CW-1:0] prod_i, prod_o;

  // Handshake and datapath
  logic          req_ready_w;
  logic          req_fire;
  logic          load_fire;
  logic          emit_fire;
  logic          slot_ok;
  logic          out_free;
  logic          step_fire;
  logic          le_c, fl_c;
  logic [EW-1:0] ie_sum, oe_sum;
  logic          ie_wrap, oe_wrap;
  logic [AW-1:0] ra_next;
  logic [AW-1:0] base_next;

  logic [nnps_pkg::PIXEL_W-1:0] store_mem [0:DEPTH-1];
  logic [nnps_pkg::PIXEL_W-1:0] rd_data;
  logic                         pend;
  logic                         pend_le;
  logic                         pend_fl;

  logic                         out_valid;
  logic [nnps_pkg::PIXEL_W-1:0] out_pixel;
  logic                         out_le;
  logic                         out_fl;

  function automatic logic [CW-1:0] clamp_dim(input logic [nnps_pkg::CFG_W-1:0] v);
    logic [CW-1:0] res;
    if (v == '0) begin
      res = CW'(1);
    end else if (int'(v) > MAX_DIM) begin
      res = CW'(MAX_DIM);
    end else begin
      res = CW'(v);
    end
    return res;
  endfunction

  // ---------------- configuration port ----------------
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[nnps_pkg::PADDR_W-1:2];

  always_comb begin
    case (cfg_idx)
      nnps_pkg::REG_SRC_WIDTH,
      nnps_pkg::REG_SRC_HEIGHT,
      nnps_pkg::REG_DST_WIDTH,
      nnps_pkg::REG_DST_HEIGHT,
      nnps_pkg::REG_ROW_STRIDE,
      nnps_pkg::REG_ROTATE_CCW: cfg_hit = 1'b1;
      default:                  cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      src_width  <= nnps_pkg::CFG_W'(1);
      src_height <= nnps_pkg::CFG_W'(1);
      dst_width  <= nnps_pkg::CFG_W'(1);
      dst_height <= nnps_pkg::CFG_W'(1);
      row_stride <= nnps_pkg::CFG_W'(1);
      rotate_ccw <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        nnps_pkg::REG_SRC_WIDTH:  src_width  <= pwdata[nnps_pkg::CFG_W-1:0];
        nnps_pkg::REG_SRC_HEIGHT: src_height <= pwdata[nnps_pkg::CFG_W-1:0];
        nnps_pkg::REG_DST_WIDTH:  dst_width  <= pwdata[nnps_pkg::CFG_W-1:0];
        nnps_pkg::REG_DST_HEIGHT: dst_height <= pwdata[nnps_pkg::CFG_W-1:0];
        nnps_pkg::REG_ROW_STRIDE: row_stride <= pwdata[nnps_pkg::CFG_W-1:0];
        nnps_pkg::REG_ROTATE_CCW: rotate_ccw <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      nnps_pkg::REG_SRC_WIDTH:  prdata = nnps_pkg::APB_DATA_W'(src_width);
      nnps_pkg::REG_SRC_HEIGHT: prdata = nnps_pkg::APB_DATA_W'(src_height);
      nnps_pkg::REG_DST_WIDTH:  prdata = nnps_pkg::APB_DATA_W'(dst_width);
      nnps_pkg::REG_DST_HEIGHT: prdata = nnps_pkg::APB_DATA_W'(dst_height);
      nnps_pkg::REG_ROW_STRIDE: prdata = nnps_pkg::APB_DATA_W'(row_stride);
      nnps_pkg::REG_ROTATE_CCW: prdata = nnps_pkg::APB_DATA_W'(rotate_ccw);
      default:                  prdata = '0;
    endcase
  end

  assign sw_c = clamp_dim(src_width);
  assign sh_c = clamp_dim(src_height);
  assign dw_c = clamp_dim(dst_width);
  assign dh_c = clamp_dim(dst_height);
  assign st_c = clamp_dim(row_stride);

  // ---------------- handshake ----------------
  assign out_free    = !out_valid || rsp.ready;
  assign slot_ok     = !pend || out_free;
  assign req_ready_w = (state == S_RUN) && slot_ok;
  assign req.ready   = req_ready_w;
  assign req_fire    = req.valid && req_ready_w;
  assign load_fire   = req_fire && (req.req_type == nnps_pkg::REQ_LOAD);
  assign emit_fire   = req_fire && (req.req_type == nnps_pkg::REQ_EMIT);
  assign div_start   = emit_fire && !scan_active;
  assign step_fire   = (emit_fire && scan_active) || ((state == S_ISSUE) && slot_ok);

  // ---------------- axis divisions at scan start ----------------
  assign div_i_num = rotate_ccw ? sh_c : sw_c;
  assign div_i_den = rotate_ccw ? dh_c : dw_c;
  assign div_o_num = rotate_ccw ? sw_c : sh_c;
  assign div_o_den = rotate_ccw ? dw_c : dh_c;

  nnps_div #(.W(CW)) u_div_inner (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_i_num),
    .den   (div_i_den),
    .done  (div_i_done),
    .quot  (div_i_quot),
    .rem   (div_i_rem)
  );

  nnps_div #(.W(CW)) u_div_outer (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_o_num),
    .den   (div_o_den),
    .done  (div_o_done),
    .quot  (div_o_quot),
    .rem   (div_o_rem)
  );

  assign prod_i = div_i_quot * stride_s;
  assign prod_o = div_o_quot * stride_s;

  // ---------------- step arithmetic ----------------
  assign le_c = inner_count >= (inner_len - CW'(1));
  assign fl_c = le_c && (outer_count >= (outer_len - CW'(1)));

  assign ie_sum  = inner_error + EW'(inner_rem);
  assign ie_wrap = ie_sum >= EW'({inner_len, 1'b0});
  assign oe_sum  = outer_error + EW'(outer_rem);
  assign oe_wrap = oe_sum >= EW'({outer_len, 1'b0});

  assign ra_next   = read_addr + inner_step + (ie_wrap ? inner_extra : '0);
  assign base_next = line_base + outer_step + (oe_wrap ? outer_extra : '0);

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_RUN;
      scan_active <= 1'b0;
      inner_count <= '0;
      outer_count <= '0;
      inner_error <= '0;
      outer_error <= '0;
      inner_rem   <= '0;
      outer_rem   <= '0;
      line_base   <= '0;
      read_addr   <= '0;
    end else begin
      case (state)
        S_RUN: begin
          if (div_start) begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_i_done && div_o_done) begin
            inner_rem   <= {div_i_rem, 1'b0};
            outer_rem   <= {div_o_rem, 1'b0};
            inner_error <= EW'(inner_len);
            outer_error <= EW'(outer_len);
            inner_count <= '0;
            outer_count <= '0;
            line_base   <= rot_s ? AW'(sw_s - CW'(1)) : '0;
            read_addr   <= rot_s ? AW'(sw_s - CW'(1)) : '0;
            scan_active <= 1'b1;
            state       <= S_ISSUE;
          end
        end
        S_ISSUE: begin
          if (slot_ok) begin
            state <= S_RUN;
          end
        end
        default: state <= S_RUN;
      endcase

      if (step_fire) begin
        if (le_c) begin
          inner_count <= '0;
          inner_error <= EW'(inner_len);
          if (fl_c) begin
            scan_active <= 1'b0;
          end else begin
            outer_count <= outer_count + CW'(1);
            outer_error <= oe_wrap ? (oe_sum - EW'({outer_len, 1'b0})) : oe_sum;
            line_base   <= base_next;
            read_addr   <= base_next;
          end
        end else begin
          inner_count <= inner_count + CW'(1);
          inner_error <= ie_wrap ? (ie_sum - EW'({inner_len, 1'b0})) : ie_sum;
          read_addr   <= ra_next;
        end
      end

      // Any register write ends the scan
      if (cfg_wr && cfg_hit) begin
        scan_active <= 1'b0;
      end
    end
  end

  // Scan geometry, latched at scan start and fixed for the scan
  always_ff @(posedge clk) begin
    if (div_start) begin
      rot_s     <= rotate_ccw;
      stride_s  <= st_c;
      sw_s      <= sw_c;
      inner_len <= rotate_ccw ? dh_c : dw_c;
      outer_len <= rotate_ccw ? dw_c : dh_c;
    end
    if ((state == S_DIV) && div_i_done && div_o_done) begin
      inner_step  <= rot_s ? AW'(prod_i) : AW'(div_i_quot);
      inner_extra <= rot_s ? AW'(stride_s) : AW'(1);
      outer_step  <= rot_s ? (AW'(0) - AW'(div_o_quot)) : AW'(prod_o);
      outer_extra <= rot_s ? {AW{1'b1}} : AW'(stride_s);
    end
  end

  // ---------------- source store ----------------
  always_ff @(posedge clk) begin
    if (load_fire) begin
      store_mem[AW'(req.load_addr)] <= req.load_pixel;
    end
    if (step_fire) begin
      rd_data <= store_mem[read_addr];
      pend_le <= le_c;
      pend_fl <= fl_c;
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (step_fire) begin
        pend <= 1'b1;
      end else if (out_free) begin
        pend <= 1'b0;
      end
      if (pend && out_free) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pend && out_free) begin
      out_pixel <= rd_data;
      out_le    <= pend_le;
      out_fl    <= pend_fl;
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.pixel      = out_pixel;
  assign rsp.line_end   = out_le;
  assign rsp.frame_last = out_fl;

  // ---------------- assertions ----------------
  `NNPS_ASSERT(a_div_holds_req, clk, rst, (state == S_DIV) |-> !req_ready_w, "req taken during division")
  `NNPS_ASSERT(a_div_lockstep, clk, rst, div_i_done == div_o_done, "axis dividers out of step")
  `NNPS_ASSERT(a_count_in_line, clk, rst, scan_active |-> (inner_count < inner_len), "inner count past line length")
  `NNPS_ASSERT_NEXT(a_last_ends_scan, clk, rst, step_fire && fl_c && !cfg_wr, !scan_active, "scan continues after last pixel")
  `NNPS_ASSERT_NEXT(a_pend_kept, clk, rst, pend && !out_free && !step_fire, pend, "waiting pixel dropped")

endmodule

// ===== bench/tb_nearest_neighbor_plane_scaler_top.sv =====
// Self-checking bench for the plane scaler: predicted pixel stream compared against the block.
module tb_nearest_neighbor_plane_scaler_top;

  localparam int WATCHDOG_CYCLES = 4000;
  localparam int SETTLE_CYCLES   = 24;
  localparam int HOLD_CYCLES     = 300;
  localparam int RANDOM_ITEMS    = 500;
  localparam int REPORT_LIMIT    = 10;
  localparam int DIM_MAX         = nnps_pkg::MAX_DIM_DEF;

  // Addresses past the register list; writes there change nothing
  localparam logic [nnps_pkg::REG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [nnps_pkg::REG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  typedef logic [nnps_pkg::LOAD_ADDR_W-1:0] addr_t;
  typedef logic [nnps_pkg::CFG_W-1:0]       dim_t;
  typedef logic [nnps_pkg::CFG_W:0]         err_t;
  typedef logic [nnps_pkg::REG_IDX_W-1:0]   reg_idx_t;

  typedef struct packed {
    logic [nnps_pkg::PIXEL_W-1:0] pixel;
    logic                         line_end;
    logic                         frame_last;
  } pixel_beat_t;

  typedef struct packed {
    logic                         req_type;
    addr_t                        addr;
    logic [nnps_pkg::PIXEL_W-1:0] data;
  } req_item_t;

  typedef enum int {RX_FREE, RX_RANDOM, RX_PERIODIC} rx_pattern_t;

  class scaled_pixel_scoreboard;
    dim_t                          regs [0:5];
    logic [nnps_pkg::PIXEL_W-1:0]  plane [int];
    addr_t                         line_base, read_addr;
    err_t                          inner_err, outer_err, inner_rem, outer_rem;
    dim_t                          inner_cnt, outer_cnt, inner_quot, outer_quot;
    bit                            scanning;
    pixel_beat_t                   pending_pixels [$];
    int unsigned mismatch_count, loads_seen, pixels_checked, frames_done, rotated_frames;

    function new();
      foreach (regs[i]) regs[i] = dim_t'(1);
      regs[nnps_pkg::REG_ROTATE_CCW] = '0;
      scanning = 1'b0;
    endfunction

    function int unsigned dim(reg_idx_t idx);
      if (regs[idx] == '0) return 1;
      if (32'(regs[idx]) > DIM_MAX) return DIM_MAX;
      return 32'(regs[idx]);
    endfunction

    function bit rotated();
      return regs[nnps_pkg::REG_ROTATE_CCW][0];
    endfunction

    function void write_reg(reg_idx_t idx, logic [nnps_pkg::APB_DATA_W-1:0] value);
      if (idx > nnps_pkg::REG_ROTATE_CCW) return;
      regs[idx] = (idx == nnps_pkg::REG_ROTATE_CCW) ? dim_t'(value[0])
                                                     : value[nnps_pkg::CFG_W-1:0];
      scanning = 1'b0;
    endfunction

    function void begin_scan();
      int unsigned sw, sh, in_src, out_src, in_len, out_len, q;
      if (scanning) return;
      sw      = dim(nnps_pkg::REG_SRC_WIDTH);
      sh      = dim(nnps_pkg::REG_SRC_HEIGHT);
      in_len  = rotated() ? dim(nnps_pkg::REG_DST_HEIGHT) : dim(nnps_pkg::REG_DST_WIDTH);
      out_len = rotated() ? dim(nnps_pkg::REG_DST_WIDTH) : dim(nnps_pkg::REG_DST_HEIGHT);
      in_src  = rotated() ? sh : sw;
      out_src = rotated() ? sw : sh;
      q          = in_src / in_len;
      inner_quot = dim_t'(q);
      inner_rem  = err_t'(2 * (in_src - q * in_len));
      q          = out_src / out_len;
      outer_quot = dim_t'(q);
      outer_rem  = err_t'(2 * (out_src - q * out_len));
      inner_err  = err_t'(in_len);
      outer_err  = err_t'(out_len);
      inner_cnt  = '0;
      outer_cnt  = '0;
      // Rotated walk starts at the rightmost visible column
      line_base  = rotated() ? addr_t'(sw - 1) : '0;
      read_addr  = line_base;
      scanning   = 1'b1;
    endfunction

    function addr_t next_read_addr();
      begin_scan();
      return read_addr;
    endfunction

    function bit is_loaded(addr_t addr);
      return plane.exists(int'(addr));
    endfunction

    function pixel_beat_t sample_next_pixel();
      int unsigned in_len, out_len, stride, acc;
      pixel_beat_t beat;
      begin_scan();
      in_len  = rotated() ? dim(nnps_pkg::REG_DST_HEIGHT) : dim(nnps_pkg::REG_DST_WIDTH);
      out_len = rotated() ? dim(nnps_pkg::REG_DST_WIDTH) : dim(nnps_pkg::REG_DST_HEIGHT);
      stride  = dim(nnps_pkg::REG_ROW_STRIDE);
      beat.pixel      = plane.exists(int'(read_addr)) ? plane[int'(read_addr)] : '0;
      beat.line_end   = (32'(inner_cnt) >= in_len - 1);
      beat.frame_last = beat.line_end && (32'(outer_cnt) >= out_len - 1);
      if (beat.line_end) begin
        inner_cnt = '0;
        inner_err = err_t'(in_len);
        if (beat.frame_last) begin
          scanning = 1'b0;
        end else begin
          outer_cnt = dim_t'(32'(outer_cnt) + 1);
          if (rotated()) begin
            line_base = addr_t'(32'(line_base) - 32'(outer_quot));
          end else begin
            line_base = addr_t'(32'(line_base) + 32'(outer_quot) * stride);
          end
          acc = 32'(outer_err) + 32'(outer_rem);
          if (acc >= 2 * out_len) begin
            acc       = acc - 2 * out_len;
            line_base = rotated() ? addr_t'(32'(line_base) - 1) : addr_t'(32'(line_base) + stride);
          end
          outer_err = err_t'(acc);
          read_addr = line_base;
        end
      end else begin
        inner_cnt = dim_t'(32'(inner_cnt) + 1);
        read_addr = addr_t'(32'(read_addr) +
                            (rotated() ? 32'(inner_quot) * stride : 32'(inner_quot)));
        acc = 32'(inner_err) + 32'(inner_rem);
        if (acc >= 2 * in_len) begin
          acc       = acc - 2 * in_len;
          read_addr = addr_t'(32'(read_addr) + (rotated() ? stride : 1));
        end
        inner_err = err_t'(acc);
      end
      return beat;
    endfunction

    function void note_request(req_item_t item);
      pixel_beat_t beat;
      if (item.req_type == nnps_pkg::REQ_LOAD) begin
        plane[int'(item.addr)] = item.data;
        loads_seen++;
      end else begin
        beat = sample_next_pixel();
        pending_pixels.push_back(beat);
        if (beat.frame_last) begin
          frames_done++;
          if (rotated()) rotated_frames++;
        end
      end
    endfunction

    function void check_pixel(pixel_beat_t got);
      pixel_beat_t want;
      pixels_checked++;
      if (pending_pixels.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("[%0t] pixel with nothing expected: pixel %02h line_end %0b frame_last %0b",
                   $time, got.pixel, got.line_end, got.frame_last);
        return;
      end
      want = pending_pixels.pop_front();
      if (want.pixel !== got.pixel || want.line_end !== got.line_end ||
          want.frame_last !== got.frame_last) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("[%0t] pixel %0d: expected %02h/%0b/%0b, got %02h/%0b/%0b (pixel/line_end/frame_last)",
                   $time, pixels_checked, want.pixel, want.line_end, want.frame_last,
                   got.pixel, got.line_end, got.frame_last);
      end
    endfunction
  endclass

  logic                            clk;
  logic                            rst;
  logic                            psel, penable, pwrite, pready;
  logic [nnps_pkg::PADDR_W-1:0]    paddr;
  logic [nnps_pkg::APB_DATA_W-1:0] pwdata, prdata;

  nnps_req_if req_ch ();
  nnps_rsp_if rsp_ch ();

  nearest_neighbor_plane_scaler_top DUT (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .rsp     (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  scaled_pixel_scoreboard pixel_sb;
  scaled_pixel_scoreboard lookahead;   // runs ahead of the driver to plan store loads

  req_item_t   item_q [$];
  int unsigned items_built, reg_writes, held_cycles, stall_cycles;
  bit          hold_off;

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (req_ch.valid && req_ch.ready)
        pixel_sb.note_request('{req_type: req_ch.req_type, addr: req_ch.load_addr,
                                data: req_ch.load_pixel});
      if (rsp_ch.valid && rsp_ch.ready)
        pixel_sb.check_pixel('{pixel: rsp_ch.pixel, line_end: rsp_ch.line_end,
                               frame_last: rsp_ch.frame_last});
    end
  end

  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
        (psel && penable)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_CYCLES) begin
      $display("Watchdog: no transaction for %0d cycles", WATCHDOG_CYCLES);
      $display("Simulation FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Output back-pressure: free-flowing, random and periodic stretches, plus one long hold
  initial begin : rsp_backpressure
    rx_pattern_t pattern;
    int unsigned remaining, phase_cnt, low_len;
    pattern   = RX_FREE;
    remaining = 0;
    phase_cnt = 0;
    low_len   = 1;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off) begin
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        held_cycles += HOLD_CYCLES;
        hold_off = 1'b0;
      end else begin
        if (remaining == 0) begin
          pattern   = rx_pattern_t'($urandom_range(0, 2));
          remaining = $urandom_range(32, 256);
          low_len   = $urandom_range(1, 4);
        end
        remaining--;
        phase_cnt++;
        case (pattern)
          RX_FREE:   rsp_ch.ready <= 1'b1;
          RX_RANDOM: rsp_ch.ready <= ($urandom_range(0, 2) != 0);
          default:   rsp_ch.ready <= ((phase_cnt % 8) >= low_len);
        endcase
      end
    end
  end

  task automatic apb_write(input reg_idx_t idx, input dim_t value);
    logic [nnps_pkg::APB_DATA_W-1:0] word;
    word = $urandom;
    word[nnps_pkg::CFG_W-1:0] = value;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= word;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    pixel_sb.write_reg(idx, word);
    lookahead.write_reg(idx, word);
    reg_writes++;
    @(posedge clk);
  endtask

  task automatic set_geometry(input dim_t sw, input dim_t sh, input dim_t dw, input dim_t dh,
                              input dim_t stride, input bit rot);
    apb_write(nnps_pkg::REG_SRC_WIDTH, sw);
    apb_write(nnps_pkg::REG_SRC_HEIGHT, sh);
    apb_write(nnps_pkg::REG_DST_WIDTH, dw);
    apb_write(nnps_pkg::REG_DST_HEIGHT, dh);
    apb_write(nnps_pkg::REG_ROW_STRIDE, stride);
    apb_write(nnps_pkg::REG_ROTATE_CCW, dim_t'(rot));
  endtask

  function automatic void add_load(addr_t addr, logic [nnps_pkg::PIXEL_W-1:0] data);
    req_item_t item;
    item.req_type = nnps_pkg::REQ_LOAD;
    item.addr     = addr;
    item.data     = data;
    item_q.push_back(item);
    lookahead.note_request(item);
    items_built++;
  endfunction

  // Fill the store entry the next pixel reads before asking for it
  function automatic void add_emit();
    req_item_t item;
    addr_t     target;
    target = lookahead.next_read_addr();
    if (!lookahead.is_loaded(target)) add_load(target, nnps_pkg::PIXEL_W'($urandom));
    item.req_type = nnps_pkg::REQ_EMIT;
    item.addr     = addr_t'($urandom);
    item.data     = nnps_pkg::PIXEL_W'($urandom);
    item_q.push_back(item);
    lookahead.note_request(item);
    lookahead.pending_pixels.delete();
    items_built++;
  endfunction

  function automatic dim_t pick_dim(bit wide);
    if (!wide) return dim_t'($urandom_range(1, 12));
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return dim_t'(DIM_MAX);
      2:       return dim_t'($urandom_range(DIM_MAX + 1, 2047));
      3:       return dim_t'(1);
      default: return dim_t'($urandom_range(1, DIM_MAX));
    endcase
  endfunction

  task automatic send_items(input bit with_gaps);
    req_item_t   item;
    int unsigned burst;
    burst = $urandom_range(1, 12);
    while (item_q.size() != 0) begin
      if (with_gaps && burst == 0) begin
        req_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        burst = $urandom_range(1, 12);
      end
      item = item_q.pop_front();
      req_ch.valid      <= 1'b1;
      req_ch.req_type   <= item.req_type;
      req_ch.load_addr  <= item.addr;
      req_ch.load_pixel <= item.data;
      do @(posedge clk); while (!req_ch.ready);
      if (burst != 0) burst--;
    end
    req_ch.valid <= 1'b0;
  endtask

  task automatic wait_idle();
    while (pixel_sb.pending_pixels.size() != 0) @(posedge clk);
    // Loads give no response; let the block finish any of them
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    int unsigned n_items, pick;
    bit          gaps, wide;
    dim_t        sw;
    pixel_sb  = new();
    lookahead = new();
    rst               <= 1'b1;
    req_ch.valid      <= 1'b0;
    req_ch.req_type   <= nnps_pkg::REQ_LOAD;
    req_ch.load_addr  <= '0;
    req_ch.load_pixel <= '0;
    psel              <= 1'b0;
    penable           <= 1'b0;
    pwrite            <= 1'b0;
    paddr             <= '0;
    pwdata            <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset geometry is 1x1 to 1x1: every pixel is a whole frame, then the scan restarts
    add_load(16'h0000, 8'hFF);
    add_emit();
    add_load(16'h0000, 8'h00);
    add_emit();
    add_load(16'hFFFF, 8'h5A);
    send_items(1'b0);
    wait_idle();

    // Zero sizes act as one; the spare address is ignored
    set_geometry('0, '0, '0, '0, '0, 1'b0);
    apb_write(REG_SPARE_HI, 11'h7FF);
    add_emit();
    add_emit();
    send_items(1'b1);
    wait_idle();

    // Oversized source width clamps; rotated walk with one-pixel lines
    set_geometry(11'h7FF, '0, 11'd2, 11'd1, 11'h7FF, 1'b1);
    add_emit();
    add_emit();
    send_items(1'b1);
    wait_idle();

    // Rotated upscale: line base steps left past address zero and wraps
    set_geometry(11'd1, 11'd2, 11'd3, 11'd4, 11'd5, 1'b1);
    repeat (9) add_emit();
    send_items(1'b1);
    wait_idle();

    // A spare write leaves the running scan alone
    apb_write(REG_SPARE_LO, dim_t'($urandom));
    repeat (3) add_emit();
    send_items(1'b0);
    wait_idle();

    items_built = 0;
    for (int phase = 0; items_built < RANDOM_ITEMS; phase++) begin
      pick = $urandom_range(0, 9);
      wide = (pick == 3 || pick == 4);
      if (pick == 1) begin
        apb_write(reg_idx_t'($urandom_range(nnps_pkg::REG_SRC_WIDTH,
                                            nnps_pkg::REG_ROTATE_CCW)),
                  pick_dim(1'b1));
      end else if (pick == 2) begin
        apb_write($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, dim_t'($urandom));
      end else if (pick != 0) begin
        sw = pick_dim(wide);
        set_geometry(sw, pick_dim(wide), pick_dim(wide), pick_dim(wide),
                     wide ? pick_dim(1'b1) :
                     ($urandom_range(0, 1) ? dim_t'(32'(sw) + $urandom_range(0, 3))
                                           : dim_t'($urandom_range(1, 16))),
                     $urandom_range(0, 1));
      end
      n_items = $urandom_range(20, 60);
      gaps    = ($urandom_range(0, 3) != 0);
      if (phase == 3) begin
        // Starve the output so the block fills up and stalls its input
        hold_off = 1'b1;
        gaps     = 1'b0;
        n_items  = 60;
      end
      repeat (n_items) begin
        if ($urandom_range(0, 4) == 0)
          add_load($urandom_range(0, 1) ? addr_t'($urandom) : addr_t'($urandom_range(0, 255)),
                   nnps_pkg::PIXEL_W'($urandom));
        else
          add_emit();
      end
      send_items(gaps);
      wait_idle();
    end

    $display("Covered %0d store loads, %0d pixels over %0d complete frames (%0d rotated),",
             pixel_sb.loads_seen, pixel_sb.pixels_checked, pixel_sb.frames_done,
             pixel_sb.rotated_frames);
    $display("%0d register writes, %0d cycles of held output; %0d pixel mismatches",
             reg_writes, held_cycles, pixel_sb.mismatch_count);
    if (pixel_sb.mismatch_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+src
src/nnps_pkg.sv
src/nnps_req_if.sv
src/nnps_rsp_if.sv
src/nnps_div.sv
src/nearest_neighbor_plane_scaler_top.sv
bench/tb_nearest_neighbor_plane_scaler_top.sv
